// File: rtl/core/pt_pkg.sv
package pt_pkg;

   localparam logic [3:0] MODE_CTRL        = 4'd0;
   localparam logic [3:0] MODE_SWEEP_WRITE = 4'd1;
   localparam logic [3:0] MODE_TIMER_LOW   = 4'd2;
   localparam logic [3:0] MODE_TIMER_HIGH  = 4'd3;
   localparam logic [3:0] MODE_ENABLE      = 4'd4;
   localparam logic [3:0] MODE_TIMER_TICK  = 4'd5;
   localparam logic [3:0] MODE_ENV_TICK    = 4'd6;
   localparam logic [3:0] MODE_LENGTH_TICK = 4'd7;
   localparam logic [3:0] MODE_SWEEP_TICK  = 4'd8;

   localparam logic [3:0]  ENV_MAX    = 4'd15;
   localparam logic [10:0] MIN_PERIOD = 11'd8;

   typedef struct packed {
      logic [1:0]  duty_select;
      logic        halt_loop;
      logic        const_volume;
      logic [3:0]  volume_or_period;
      logic        sweep_on;
      logic [2:0]  sweep_divider_period;
      logic        sweep_down;
      logic [2:0]  sweep_amount;
      logic        sweep_reload_flag;
      logic [2:0]  sweep_divider;
      logic [10:0] tone_period;
      logic [10:0] tone_timer;
      logic [2:0]  sequence_step;
      logic [7:0]  note_length;
      logic        channel_enabled;
      logic        envelope_restart;
      logic [3:0]  envelope_level;
      logic [3:0]  envelope_divider;
   } chan_state_type;

   typedef struct packed {
      logic [3:0] level;
      logic       muted;
      logic       length_active;
   } chan_result_type;

   function automatic logic duty_bit(input logic [1:0] sel, input logic [2:0] step);
      logic [7:0] row;
      case (sel)
         2'd0:    row = 8'b0000_0010;
         2'd1:    row = 8'b0000_0110;
         2'd2:    row = 8'b0001_1110;
         2'd3:    row = 8'b1111_1001;
         default: row = 8'b0000_0000;
      endcase
      return row[step];
   endfunction

   function automatic logic [7:0] length_load(input logic [4:0] idx);
      logic [7:0] v;
      case (idx)
         5'd0:  v = 8'd10;   5'd1:  v = 8'd254;  5'd2:  v = 8'd20;   5'd3:  v = 8'd2;
         5'd4:  v = 8'd40;   5'd5:  v = 8'd4;    5'd6:  v = 8'd80;   5'd7:  v = 8'd6;
         5'd8:  v = 8'd160;  5'd9:  v = 8'd8;    5'd10: v = 8'd60;   5'd11: v = 8'd10;
         5'd12: v = 8'd14;   5'd13: v = 8'd12;   5'd14: v = 8'd26;   5'd15: v = 8'd14;
         5'd16: v = 8'd12;   5'd17: v = 8'd16;   5'd18: v = 8'd24;   5'd19: v = 8'd18;
         5'd20: v = 8'd48;   5'd21: v = 8'd20;   5'd22: v = 8'd96;   5'd23: v = 8'd22;
         5'd24: v = 8'd192;  5'd25: v = 8'd24;   5'd26: v = 8'd72;   5'd27: v = 8'd26;
         5'd28: v = 8'd16;   5'd29: v = 8'd28;   5'd30: v = 8'd32;   5'd31: v = 8'd30;
         default: v = 8'd0;
      endcase
      return v;
   endfunction

endpackage

// File: rtl/core/pulse_tone_channel.sv
// channel  | ports                                         | direction
// req      | req_valid, req_stall, req_mode, req_data_byte | in (item in)
// rsp      | rsp_valid, rsp_stall, rsp_level, rsp_muted,   | out (item out)
//          | rsp_length_active                             |
// csr      | csr_wr_en, csr_wr_data (first_channel)        | in
//
// One item per cycle sustained while rsp_stall is low; an accepted item passes
// through the input register, then the channel update into the result register.
// Synchronous active-high reset clears channel state; first_channel resets to 1.
// A stalled result holds the result register; req_stall rises only when the
// input register is full and cannot move on.
module pulse_tone_channel
   import pt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [3:0] req_mode,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_level,
   output logic       rsp_muted,
   output logic       rsp_length_active,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   logic            first_channel_ff;
   logic            in_valid_ff;
   logic [3:0]      in_mode_ff;
   logic [7:0]      in_data_ff;
   logic            out_valid_ff;
   chan_result_type out_ff;
   chan_result_type result;
   logic            advance;
   logic            item_en;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign item_en   = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_channel_ff <= 1'b1;
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            first_channel_ff <= csr_wr_data;
         end
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_mode_ff <= req_mode;
         in_data_ff <= req_data_byte;
      end
      if (item_en) begin
         out_ff <= result;
      end
   end

   pt_core u_core (
      .clock         (clock),
      .reset         (reset),
      .item_en       (item_en),
      .mode          (in_mode_ff),
      .data_byte     (in_data_ff),
      .first_channel (first_channel_ff),
      .result        (result)
   );

   assign rsp_valid         = out_valid_ff;
   assign rsp_level         = out_ff.level;
   assign rsp_muted         = out_ff.muted;
   assign rsp_length_active = out_ff.length_active;

endmodule

// File: rtl/core/pt_sweep.sv
module pt_sweep
   import pt_pkg::*;
(
   input  logic [10:0] period,
   input  logic [2:0]  amount,
   input  logic        down,
   input  logic        first_channel,
   output logic [10:0] target,
   output logic        out_of_range
);

   logic [10:0] delta;
   logic [11:0] sum;

   // bit 11 flags overflow going up, borrow going down
   always_comb begin
      delta = period >> amount;
      if (down) begin
         sum = {1'b0, period} - {1'b0, delta} - {11'd0, first_channel};
      end else begin
         sum = {1'b0, period} + {1'b0, delta};
      end
      target       = sum[10:0];
      out_of_range = sum[11];
   end

endmodule

// File: rtl/core/pt_core.sv
module pt_core
   import pt_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            item_en,
   input  logic [3:0]      mode,
   input  logic [7:0]      data_byte,
   input  logic            first_channel,
   output chan_result_type result
);

   chan_state_type state_ff;
   chan_state_type state_in;
   logic [10:0]    cur_target;
   logic           cur_oor;
   logic           cur_muted;
   logic [10:0]    nxt_target;
   logic           nxt_oor;
   logic           nxt_muted;

   pt_sweep u_sweep_cur (
      .period        (state_ff.tone_period),
      .amount        (state_ff.sweep_amount),
      .down          (state_ff.sweep_down),
      .first_channel (first_channel),
      .target        (cur_target),
      .out_of_range  (cur_oor)
   );

   assign cur_muted = (state_ff.tone_period < MIN_PERIOD) || cur_oor
                   || (state_ff.note_length == 8'd0) || !state_ff.channel_enabled;

   always_comb begin
      state_in = state_ff;
      if (item_en) begin
         case (mode)
            MODE_CTRL: begin
               state_in.duty_select      = data_byte[7:6];
               state_in.halt_loop        = data_byte[5];
               state_in.const_volume     = data_byte[4];
               state_in.volume_or_period = data_byte[3:0];
               state_in.envelope_restart = 1'b1;
            end
            MODE_SWEEP_WRITE: begin
               state_in.sweep_on             = data_byte[7];
               state_in.sweep_divider_period = data_byte[6:4];
               state_in.sweep_down           = data_byte[3];
               state_in.sweep_amount         = data_byte[2:0];
               state_in.sweep_reload_flag    = 1'b1;
            end
            MODE_TIMER_LOW: begin
               state_in.tone_period[7:0] = data_byte;
            end
            MODE_TIMER_HIGH: begin
               state_in.tone_period[10:8] = data_byte[2:0];
               if (state_ff.channel_enabled) begin
                  state_in.note_length = length_load(data_byte[7:3]);
               end
               state_in.sequence_step    = 3'd0;
               state_in.envelope_restart = 1'b1;
            end
            MODE_ENABLE: begin
               state_in.channel_enabled = data_byte[0];
               if (!data_byte[0]) begin
                  state_in.note_length = 8'd0;
               end
            end
            MODE_TIMER_TICK: begin
               if (state_ff.tone_timer == 11'd0) begin
                  state_in.tone_timer    = state_ff.tone_period;
                  state_in.sequence_step = state_ff.sequence_step + 3'd1;
               end else begin
                  state_in.tone_timer = state_ff.tone_timer - 11'd1;
               end
            end
            MODE_ENV_TICK: begin
               if (state_ff.envelope_restart) begin
                  state_in.envelope_level   = ENV_MAX;
                  state_in.envelope_divider = state_ff.volume_or_period;
                  state_in.envelope_restart = 1'b0;
               end else if (state_ff.envelope_divider != 4'd0) begin
                  state_in.envelope_divider = state_ff.envelope_divider - 4'd1;
               end else begin
                  state_in.envelope_divider = state_ff.volume_or_period;
                  if (state_ff.envelope_level != 4'd0) begin
                     state_in.envelope_level = state_ff.envelope_level - 4'd1;
                  end else if (state_ff.halt_loop) begin
                     state_in.envelope_level = ENV_MAX;
                  end
               end
            end
            MODE_LENGTH_TICK: begin
               if (!state_ff.halt_loop && state_ff.note_length != 8'd0) begin
                  state_in.note_length = state_ff.note_length - 8'd1;
               end
            end
            MODE_SWEEP_TICK: begin
               if (state_ff.sweep_divider == 3'd0 && state_ff.sweep_on
                   && state_ff.sweep_amount != 3'd0 && !cur_muted) begin
                  state_in.tone_period = cur_target;
               end
               if (state_ff.sweep_divider == 3'd0 || state_ff.sweep_reload_flag) begin
                  state_in.sweep_divider     = state_ff.sweep_divider_period;
                  state_in.sweep_reload_flag = 1'b0;
               end else begin
                  state_in.sweep_divider = state_ff.sweep_divider - 3'd1;
               end
            end
            default: begin
               state_in = state_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   pt_sweep u_sweep_nxt (
      .period        (state_in.tone_period),
      .amount        (state_in.sweep_amount),
      .down          (state_in.sweep_down),
      .first_channel (first_channel),
      .target        (nxt_target),
      .out_of_range  (nxt_oor)
   );

   always_comb begin
      nxt_muted = (state_in.tone_period < MIN_PERIOD) || nxt_oor
               || (state_in.note_length == 8'd0) || !state_in.channel_enabled;
      result.muted         = nxt_muted;
      result.length_active = (state_in.note_length != 8'd0);
      result.level         = 4'd0;
      if (!nxt_muted && duty_bit(state_in.duty_select, state_in.sequence_step)
          && (nxt_target == nxt_target)) begin
         result.level = state_in.const_volume ? state_in.volume_or_period
                                              : state_in.envelope_level;
      end
   end

endmodule

// File: verif/pulse_tone_channel_tb.sv
`timescale 1ns / 1ps

module pulse_tone_channel_tb;
   import pt_pkg::*;

   localparam logic [3:0] MODE_SPARE_LO = 4'd9;
   localparam logic [3:0] MODE_SPARE_HI = 4'd15;
   localparam int         PERIOD_MAX    = 'h7FF;
   localparam int         STALL_LIMIT   = 2000;
   localparam int         LONG_HOLD     = 300;

   // bit {duty, step}
   localparam logic [31:0] DUTY_WAVES =
      {8'b1111_1001, 8'b0001_1110, 8'b0000_0110, 8'b0000_0010};
   // entry n at bits [8n +: 8]
   localparam logic [255:0] LENGTH_LOADS = {
      8'd30, 8'd32, 8'd28, 8'd16, 8'd26, 8'd72, 8'd24, 8'd192,
      8'd22, 8'd96, 8'd20, 8'd48, 8'd18, 8'd24, 8'd16, 8'd12,
      8'd14, 8'd26, 8'd12, 8'd14, 8'd10, 8'd60, 8'd8,  8'd160,
      8'd6,  8'd80, 8'd4,  8'd40, 8'd2,  8'd20, 8'd254, 8'd10};

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [3:0] req_mode = '0;
   logic [7:0] req_data_byte = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [3:0] rsp_level;
   logic       rsp_muted;
   logic       rsp_length_active;
   logic       csr_wr_en = 1'b0;
   logic       csr_wr_data = 1'b0;

   chan_state_type  ch;
   logic            first_channel_cfg;
   chan_result_type expected_results[$];
   int              mismatch_count = 0;
   int              src_idle_max = 0;
   int              sink_idle_max = 0;
   int              hold_request = 0;
   int              hold_served = 0;
   int              hold_left = 0;
   int              sink_wait = 0;
   int              quiet_cycles = 0;

   pulse_tone_channel u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_level        (rsp_level),
      .rsp_muted        (rsp_muted),
      .rsp_length_active(rsp_length_active),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always #5 clock = ~clock;

   function automatic int sweep_goal();
      int base;
      int delta;
      base  = ch.tone_period;
      delta = ch.tone_period >> ch.sweep_amount;
      if (ch.sweep_down) begin
         return base - delta - (first_channel_cfg ? 1 : 0);
      end
      return base + delta;
   endfunction

   function automatic logic channel_silenced();
      int goal;
      goal = sweep_goal();
      return ch.tone_period < MIN_PERIOD || goal < 0 || goal > PERIOD_MAX
         || ch.note_length == 8'd0 || !ch.channel_enabled;
   endfunction

   function automatic chan_result_type advance_channel(input logic [3:0] mode,
                                                        input logic [7:0] data);
      chan_result_type r;
      case (mode)
         MODE_CTRL: begin
            ch.duty_select      = data[7:6];
            ch.halt_loop        = data[5];
            ch.const_volume     = data[4];
            ch.volume_or_period = data[3:0];
            ch.envelope_restart = 1'b1;
         end
         MODE_SWEEP_WRITE: begin
            ch.sweep_on             = data[7];
            ch.sweep_divider_period = data[6:4];
            ch.sweep_down           = data[3];
            ch.sweep_amount         = data[2:0];
            ch.sweep_reload_flag    = 1'b1;
         end
         MODE_TIMER_LOW: ch.tone_period[7:0] = data;
         MODE_TIMER_HIGH: begin
            ch.tone_period[10:8] = data[2:0];
            if (ch.channel_enabled)
               ch.note_length = LENGTH_LOADS[data[7:3]*8 +: 8];
            ch.sequence_step    = 3'd0;
            ch.envelope_restart = 1'b1;
         end
         MODE_ENABLE: begin
            ch.channel_enabled = data[0];
            if (!data[0])
               ch.note_length = 8'd0;
         end
         MODE_TIMER_TICK: begin
            if (ch.tone_timer == 11'd0) begin
               ch.tone_timer    = ch.tone_period;
               ch.sequence_step = ch.sequence_step + 3'd1;
            end else begin
               ch.tone_timer = ch.tone_timer - 11'd1;
            end
         end
         MODE_ENV_TICK: begin
            if (ch.envelope_restart) begin
               ch.envelope_level   = ENV_MAX;
               ch.envelope_divider = ch.volume_or_period;
               ch.envelope_restart = 1'b0;
            end else if (ch.envelope_divider > 4'd0) begin
               ch.envelope_divider = ch.envelope_divider - 4'd1;
            end else begin
               ch.envelope_divider = ch.volume_or_period;
               if (ch.envelope_level > 4'd0)
                  ch.envelope_level = ch.envelope_level - 4'd1;
               else if (ch.halt_loop)
                  ch.envelope_level = ENV_MAX;
            end
         end
         MODE_LENGTH_TICK: begin
            if (!ch.halt_loop && ch.note_length > 8'd0)
               ch.note_length = ch.note_length - 8'd1;
         end
         MODE_SWEEP_TICK: begin
            if (ch.sweep_divider == 3'd0 && ch.sweep_on && ch.sweep_amount != 3'd0
                && !channel_silenced())
               ch.tone_period = 11'(sweep_goal());
            if (ch.sweep_divider == 3'd0 || ch.sweep_reload_flag) begin
               ch.sweep_divider     = ch.sweep_divider_period;
               ch.sweep_reload_flag = 1'b0;
            end else begin
               ch.sweep_divider = ch.sweep_divider - 3'd1;
            end
         end
         default: ;
      endcase
      r.muted         = channel_silenced();
      r.length_active = ch.note_length != 8'd0;
      r.level         = 4'd0;
      if (!r.muted && DUTY_WAVES[{ch.duty_select, ch.sequence_step}])
         r.level = ch.const_volume ? ch.volume_or_period : ch.envelope_level;
      return r;
   endfunction

   // predict on input, compare on output
   always @(posedge clock) begin : scoreboard
      chan_result_type want;
      chan_result_type got;
      if (reset) begin
         ch = '0;
         first_channel_cfg = 1'b1;
         expected_results.delete();
      end else begin
         if (csr_wr_en)
            first_channel_cfg = csr_wr_data;
         if (req_valid && !req_stall) begin
            want = advance_channel(req_mode, req_data_byte);
            expected_results.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_level, rsp_muted, rsp_length_active};
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected item level %0d muted %0b length_active %0b",
                        $time, got.level, got.muted, got.length_active);
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               if (got.level !== want.level) begin
                  $display("%0t: level expected %0d, actual %0d",
                           $time, want.level, got.level);
                  mismatch_count++;
               end
               if (got.muted !== want.muted) begin
                  $display("%0t: muted expected %0b, actual %0b",
                           $time, want.muted, got.muted);
                  mismatch_count++;
               end
               if (got.length_active !== want.length_active) begin
                  $display("%0t: length_active expected %0b, actual %0b",
                           $time, want.length_active, got.length_active);
                  mismatch_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin : result_sink
      if (reset) begin
         rsp_stall <= 1'b0;
         sink_wait = 0;
         hold_left = 0;
         hold_served = hold_request;
      end else begin
         if (hold_request != hold_served) begin
            hold_left   = LONG_HOLD;
            hold_served = hold_request;
         end
         if (rsp_valid && !rsp_stall && sink_idle_max > 0)
            sink_wait = $urandom_range(0, sink_idle_max);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (sink_wait > 0) begin
            sink_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   task automatic send_item(input logic [3:0] mode, input logic [7:0] data);
      int gap;
      gap = (src_idle_max > 0) ? $urandom_range(0, src_idle_max) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= mode;
      req_data_byte <= data;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_first_channel(input logic value);
      wait_drained();
      repeat (3) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic test_after_reset();
      send_item(MODE_TIMER_TICK, 8'h00);
      send_item(MODE_SPARE_LO, 8'hFF);
      send_item(MODE_SPARE_HI, 8'h00);
   endtask

   task automatic test_register_writes();
      send_item(MODE_ENABLE, 8'h01);
      send_item(MODE_CTRL, 8'hBF);
      send_item(MODE_TIMER_LOW, 8'hFF);
      send_item(MODE_TIMER_HIGH, 8'h08);
      send_item(MODE_TIMER_TICK, 8'hFF);
      send_item(MODE_TIMER_TICK, 8'h00);
      send_item(MODE_CTRL, 8'h00);
      send_item(MODE_ENV_TICK, 8'h00);
      send_item(MODE_LENGTH_TICK, 8'hFF);
      send_item(MODE_SWEEP_WRITE, 8'h00);
      send_item(MODE_TIMER_HIGH, 8'hFF);
      send_item(MODE_SWEEP_WRITE, 8'hFF);
      send_item(MODE_SWEEP_TICK, 8'h00);
      send_item(MODE_ENABLE, 8'hFE);
   endtask

   // negate underflow with each complement, then upward overflow
   task automatic test_sweep_limits();
      write_first_channel(1'b1);
      send_item(MODE_ENABLE, 8'h01);
      send_item(MODE_TIMER_LOW, 8'h00);
      send_item(MODE_TIMER_HIGH, 8'h00);
      send_item(MODE_SWEEP_WRITE, 8'h88);
      send_item(MODE_SWEEP_TICK, 8'h00);
      write_first_channel(1'b0);
      send_item(MODE_SWEEP_TICK, 8'h00);
      send_item(MODE_TIMER_LOW, 8'hFF);
      send_item(MODE_TIMER_HIGH, 8'h07);
      send_item(MODE_SWEEP_WRITE, 8'h81);
      send_item(MODE_SWEEP_TICK, 8'h00);
   endtask

   task automatic play_random_note();
      logic [7:0] b;
      int         ticks;
      int         pick;
      b = 8'($urandom);
      send_item(MODE_ENABLE, ($urandom_range(0, 7) == 0) ? (b & 8'hFE) : (b | 8'h01));
      b = 8'($urandom);
      send_item(MODE_CTRL, b);
      b = 8'($urandom);
      send_item(MODE_SWEEP_WRITE, b);
      b = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 24));
      send_item(MODE_TIMER_LOW, b);
      b = 8'($urandom);
      if ($urandom_range(0, 3) != 0)
         b[2:0] = 3'd0;
      send_item(MODE_TIMER_HIGH, b);
      ticks = $urandom_range(8, 30);
      repeat (ticks) begin
         pick = $urandom_range(0, 99);
         b = 8'($urandom);
         if (pick < 55)
            send_item(MODE_TIMER_TICK, b);
         else if (pick < 70)
            send_item(MODE_ENV_TICK, b);
         else if (pick < 82)
            send_item(MODE_LENGTH_TICK, b);
         else if (pick < 92)
            send_item(MODE_SWEEP_TICK, b);
         else
            send_item(4'($urandom_range(MODE_CTRL, MODE_ENABLE)), b);
      end
   endtask

   task automatic test_random_notes(input int notes);
      int n;
      for (n = 0; n < notes; n++) begin
         if (n % 8 == 0) begin
            src_idle_max  = ($urandom_range(0, 2) == 0) ? 0 : 12;
            sink_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 12;
         end
         play_random_note();
         if ($urandom_range(0, 5) == 0)
            wait_drained();
      end
   endtask

   task automatic test_random_noise(input int items);
      logic [7:0] b;
      repeat (items) begin
         b = 8'($urandom);
         send_item(4'($urandom_range(0, 15)), b);
      end
   endtask

   // long receiver hold-off while items keep coming
   task automatic test_backpressure();
      logic [7:0] b;
      src_idle_max = 0;
      hold_request++;
      repeat (40) begin
         b = 8'($urandom);
         send_item(4'($urandom_range(MODE_CTRL, MODE_SWEEP_TICK)), b);
      end
      wait_drained();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_after_reset();
      test_register_writes();
      test_sweep_limits();
      test_random_notes(18);
      write_first_channel(1'b1);
      test_backpressure();
      test_random_notes(16);
      write_first_channel(1'b0);
      sink_idle_max = 12;
      src_idle_max  = 6;
      test_random_noise(150);
      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
